### rtl/batch_norm_inference_defines.svh
// Assertion macros shared by the RTL files.
`ifndef BATCH_NORM_INFERENCE_DEFINES_SVH
`define BATCH_NORM_INFERENCE_DEFINES_SVH
`ifndef SYNTHESIS
`define BNI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BNI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BNI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BNI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/bni_pkg.sv
package bni_pkg;
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_DIV,
    ST_SHIFT
  } load_state_t;

  localparam int MAX_CHANNELS = 1024;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_EPSILON = 1'b1;

  localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;
endpackage

### rtl/batch_norm_inference.sv
// Data beats: one per cycle while the result register is free; an accepted
// beat passes the table read, the registered multiply-add and the output register.
// A result held by out_stall stalls the input in the same cycle.
// Load beats: the iterative root and divide run, the input stalling
// until the tables are written. Reset clears the channel counter and control
// state and sets channel_count to 1 and epsilon_q16 to 66; the tables are unset.
`include "batch_norm_inference_defines.svh"
module batch_norm_inference (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [9:0]         param_channel,
  input  logic signed [15:0] gamma_q8,
  input  logic signed [15:0] beta_q8,
  input  logic signed [15:0] mean_q8,
  input  logic [31:0]        variance_q16,
  input  logic signed [15:0] sample_q8,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_value,
  output logic [9:0]         out_channel
);
  import bni_pkg::*;

  localparam int AW = $clog2(MAX_CHANNELS);

  logic [10:0] channel_count;
  logic [31:0] epsilon_q16;
  logic [AW-1:0] channel_counter;
  logic [AW-1:0] load_ch;
  logic          load_ok;
  logic          busy, done;
  logic signed [31:0] scale_new, shift_new;
  logic [AW-1:0] raddr;
  logic [31:0] scale_rd, shift_rd;
  logic          s1_valid;
  logic [9:0]    s1_ch;
  logic signed [15:0] s1_x;
  logic          s2_valid;
  logic [9:0]    s2_ch;
  logic signed [47:0] s2_acc;
  logic          in_fire, data_fire, pipe_go;
  logic signed [47:0] rnd;
  logic signed [15:0] y;
  logic [10:0]   cnt_lim;
  logic          load_go;

  assign cfg_ready = 1'b1;
  // Pipeline moves when the output register is free or being taken.
  assign pipe_go   = !out_valid || !out_stall;
  assign in_stall  = busy || done || !pipe_go;
  assign in_fire   = in_valid && !in_stall;
  assign data_fire = in_fire && req_type == REQ_DATA;
  // A held first stage keeps re-reading its own entry so that its table data stays put.
  assign raddr     = pipe_go ? channel_counter : AW'(s1_ch);

  always_comb begin
    if (channel_count == 11'd0) begin
      cnt_lim = 11'd1;
    end else if (channel_count > 11'(MAX_CHANNELS)) begin
      cnt_lim = 11'(MAX_CHANNELS);
    end else begin
      cnt_lim = channel_count;
    end
  end

  assign load_go = in_fire && req_type == REQ_LOAD;

  bni_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .start   (load_go),
    .gamma   (gamma_q8),
    .beta    (beta_q8),
    .mean    (mean_q8),
    .var_eps ({1'b0, variance_q16} + {1'b0, epsilon_q16}),
    .busy    (busy),
    .done    (done),
    .scale   (scale_new),
    .shift   (shift_new)
  );

  bni_ram #(.Width(32), .Depth(MAX_CHANNELS)) u_scale (
    .clk (clk), .we (done && load_ok), .waddr (load_ch), .wdata (scale_new),
    .raddr (raddr), .rdata (scale_rd)
  );
  bni_ram #(.Width(32), .Depth(MAX_CHANNELS)) u_shift (
    .clk (clk), .we (done && load_ok), .waddr (load_ch), .wdata (shift_new),
    .raddr (raddr), .rdata (shift_rd)
  );

  assign rnd = s2_acc + 48'sd32768;
  always_comb begin
    if (rnd >>> 16 > 48'sd32767) begin
      y = 16'sh7FFF;
    end else if (rnd >>> 16 < -48'sd32768) begin
      y = 16'sh8000;
    end else begin
      y = 16'(rnd >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= 11'd1;
      epsilon_q16     <= 32'd66;
      channel_counter <= '0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT: begin
            channel_count   <= cfg_data[10:0];
            channel_counter <= '0;
          end
          CFG_EPSILON: epsilon_q16 <= cfg_data;
          default: ;
        endcase
      end else if (data_fire) begin
        channel_counter <= (11'(channel_counter) + 11'd1 >= cnt_lim) ? '0
                         : channel_counter + 1'b1;
      end
      if (pipe_go) begin
        s1_valid <= data_fire;
        s2_valid <= s1_valid;
        if (s2_valid) begin
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
    if (load_go) begin
      load_ch <= AW'(param_channel);
      load_ok <= 32'(param_channel) < MAX_CHANNELS;
    end
    if (pipe_go) begin
      s1_ch  <= 10'(channel_counter);
      s1_x   <= sample_q8;
      s2_ch  <= s1_ch;
      s2_acc <= s1_x * $signed(scale_rd) + ($signed({{16{shift_rd[31]}}, shift_rd}) <<< 8);
      if (s2_valid) begin
        out_value   <= y;
        out_channel <= s2_ch;
      end
    end
  end

  `BNI_ASSERT_IMPL(a_no_input_when_busy, clk, rst, busy, in_stall)
  `BNI_ASSERT_IMPL(a_counter_bound, clk, rst, 1'b1, 11'(channel_counter) < cnt_lim)
  `BNI_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid)
endmodule

### rtl/bni_ram.sv
module bni_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/bni_coef.sv
`include "batch_norm_inference_defines.svh"
// Iterative unit that turns one channel's parameters into scale and shift.
// The root takes 25 steps and the restoring divide 41, one bit per cycle.
module bni_coef (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] gamma,
  input  logic signed [15:0] beta,
  input  logic signed [15:0] mean,
  input  logic [32:0]        var_eps,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] scale,
  output logic signed [31:0] shift
);
  import bni_pkg::*;

  load_state_t state, state_next;
  logic [5:0]  step;
  logic [49:0] rad;
  logic [49:0] rem_sq;
  logic [24:0] root;
  logic [40:0] dividend;
  logic [40:0] quot;
  logic [41:0] rem_dv;
  logic signed [15:0] g, b, m;
  logic [49:0] trial_sq;
  logic [41:0] rem_shift;
  logic [41:0] trial_dv;
  logic signed [33:0] scale_sat;
  logic signed [47:0] prod;
  logic signed [47:0] prod_tr;
  logic signed [48:0] shift_full;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_ROOT;
      ST_ROOT:  if (step == 6'd24) state_next = ST_DIV;
      ST_DIV:   if (step == 6'd40) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Digit-by-digit step for the root, two radicand bits a cycle.
  assign trial_sq  = {rem_sq[47:0], rad[49:48]} - {23'd0, root, 2'b01};
  assign rem_shift = {rem_dv[40:0], dividend[40]};
  assign trial_dv  = rem_shift - {17'd0, root};

  always_comb begin
    if (quot[40:31] != 10'd0) begin
      scale_sat = g[15] ? 34'sd0 - 34'sh8000_0000 : 34'sh7FFF_FFFF;
    end else begin
      scale_sat = g[15] ? -$signed({3'd0, quot[30:0]}) : $signed({3'd0, quot[30:0]});
    end
    if (root == 25'd0) begin
      scale_sat = (g == 16'sd0) ? 34'sd0 : (g[15] ? 34'sd0 - 34'sh8000_0000 : 34'sh7FFF_FFFF);
    end
  end

  assign prod = $signed(scale_sat[31:0]) * m;
  assign prod_tr = prod[47] ? -((-prod) >>> 8) : (prod >>> 8);
  assign shift_full = $signed({{25{b[15]}}, b, 8'd0}) - $signed({prod_tr[47], prod_tr});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_SHIFT);
    end
    unique case (state)
      ST_IDLE: begin
        step     <= 6'd0;
        rad      <= {1'b0, var_eps, 16'd0};
        rem_sq   <= 50'd0;
        root     <= 25'd0;
        g        <= gamma;
        b        <= beta;
        m        <= mean;
        dividend <= {gamma[15] ? 16'd0 - gamma : gamma, 25'd0} >> 1;
        quot     <= 41'd0;
        rem_dv   <= 42'd0;
      end
      ST_ROOT: begin
        step <= (step == 6'd24) ? 6'd0 : step + 6'd1;
        rad  <= {rad[47:0], 2'b00};
        if (!trial_sq[49]) begin
          rem_sq <= trial_sq;
          root   <= {root[23:0], 1'b1};
        end else begin
          rem_sq <= {rem_sq[47:0], rad[49:48]};
          root   <= {root[23:0], 1'b0};
        end
      end
      ST_DIV: begin
        step     <= step + 6'd1;
        dividend <= {dividend[39:0], 1'b0};
        if (root != 25'd0 && !trial_dv[41]) begin
          rem_dv <= trial_dv;
          quot   <= {quot[39:0], 1'b1};
        end else begin
          rem_dv <= rem_shift;
          quot   <= {quot[39:0], 1'b0};
        end
      end
      ST_SHIFT: begin
        scale <= scale_sat[31:0];
        if (shift_full > 49'sh0_7FFF_FFFF) begin
          shift <= SAT_POS;
        end else if (shift_full < -49'sh0_8000_0000) begin
          shift <= SAT_NEG;
        end else begin
          shift <= 32'(shift_full);
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

  `BNI_ASSERT_IMPL(a_done_after_shift, clk, rst, done, $past(state) == ST_SHIFT)
  `BNI_ASSERT_NEXT(a_start_leaves_idle, clk, rst, start && state == ST_IDLE, state == ST_ROOT)
  `BNI_ASSERT_IMPL(a_root_step_bound, clk, rst, state == ST_ROOT, step < 6'd25)
endmodule
